// ===== hw/rtl/sfcs_pkg.sv =====
package sfcs_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int COPIES       = 3;
    localparam int PAGE_BYTES   = 256;

    localparam int IDX_W     = $clog2(BUFFER_BYTES);
    localparam int CP_W      = $clog2(COPIES);
    localparam int MEM_DEPTH = COPIES * BUFFER_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int PD_W      = COPIES - 1;
    localparam int FI_W      = $clog2(BUFFER_BYTES + 1);

    // Request codes.
    localparam logic [3:0] REQ_READ     = 4'd0;
    localparam logic [3:0] REQ_PG_START = 4'd1;
    localparam logic [3:0] REQ_PG_DATA  = 4'd2;
    localparam logic [3:0] REQ_SE       = 4'd3;
    localparam logic [3:0] REQ_CE       = 4'd4;
    localparam logic [3:0] REQ_ID       = 4'd5;
    localparam logic [3:0] REQ_BUSY     = 4'd6;
    localparam logic [3:0] REQ_BUS_BYTE = 4'd7;
    localparam logic [3:0] REQ_FETCH    = 4'd8;

    // Flash opcodes.
    localparam logic [7:0] OP_FAST_READ = 8'h0B;
    localparam logic [7:0] OP_PROGRAM   = 8'h02;
    localparam logic [7:0] OP_STATUS    = 8'h05;
    localparam logic [7:0] OP_WREN      = 8'h06;
    localparam logic [7:0] OP_SE        = 8'h20;
    localparam logic [7:0] OP_CE        = 8'hC7;
    localparam logic [7:0] OP_RDID      = 8'h9F;
    localparam logic [7:0] WIP_MASK     = 8'h01;

    localparam logic [1:0] KIND_BUS  = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUS_ERR  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    localparam logic [3:0] ATTEMPTS_RESET = 4'd9;
    localparam logic       REG_MAX_ATTEMPTS = 1'b0;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [23:0] addr;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic        bus_error;
    } t_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  bus_out_byte;
        logic        frame_end;
        logic [7:0]  host_byte;
        logic [1:0]  status;
        logic        busy_flag;
        logic [23:0] device_id;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        CL_NONE,
        CL_START,
        CL_PG_DATA,
        CL_BUS,
        CL_FETCH
    } t_cls;

    typedef struct packed {
        t_cls  cls;
        t_item item;
    } t_cmd;

    typedef struct packed {
        logic       room;
        logic [2:0] count;
    } t_oq_status;

    function automatic t_result mk_bus(input logic [7:0] b, input logic fe);
        t_result r;
        r = '0;
        r.out_kind     = KIND_BUS;
        r.bus_out_byte = b;
        r.frame_end    = fe;
        return r;
    endfunction

    function automatic t_result mk_host(input logic [7:0] b);
        t_result r;
        r = '0;
        r.out_kind  = KIND_HOST;
        r.host_byte = b;
        return r;
    endfunction

    function automatic t_result mk_done(input logic [1:0] st, input logic busy,
                                        input logic [23:0] id);
        t_result r;
        r = '0;
        r.out_kind  = KIND_DONE;
        r.status    = st;
        r.busy_flag = busy;
        r.device_id = id;
        return r;
    endfunction

endpackage

// ===== hw/rtl/sfcs_ram.sv =====
module sfcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sfcs_front.sv =====
module sfcs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfcs_pkg::t_item   i_item,
    output logic              o_full,
    output logic              o_valid,
    output sfcs_pkg::t_cmd    o_cmd,
    input  logic              i_take
);

    sfcs_pkg::t_cmd r_q [2];
    logic           r_rp;
    logic [1:0]     r_cnt;
    sfcs_pkg::t_cls cls;
    logic           wr;
    logic           rd;
    logic           wp;

    always_comb begin
        unique case (i_item.req_type) inside
            sfcs_pkg::REQ_READ, sfcs_pkg::REQ_PG_START, sfcs_pkg::REQ_SE,
            sfcs_pkg::REQ_CE, sfcs_pkg::REQ_ID, sfcs_pkg::REQ_BUSY: cls = sfcs_pkg::CL_START;
            sfcs_pkg::REQ_PG_DATA:  cls = sfcs_pkg::CL_PG_DATA;
            sfcs_pkg::REQ_BUS_BYTE: cls = sfcs_pkg::CL_BUS;
            sfcs_pkg::REQ_FETCH:    cls = sfcs_pkg::CL_FETCH;
            default:                cls = sfcs_pkg::CL_NONE;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    // Unknown request codes are accepted and dropped here.
    assign wr      = i_push && !o_full && (cls != sfcs_pkg::CL_NONE);
    assign rd      = o_valid && i_take;
    assign wp      = r_rp ^ r_cnt[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) begin
            r_q[wp] <= '{cls: cls, item: i_item};
        end
    end

endmodule

// ===== hw/rtl/sfcs_outq.sv =====
module sfcs_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_nres,
    input  sfcs_pkg::t_result     i_res0,
    input  sfcs_pkg::t_result     i_res1,
    output sfcs_pkg::t_oq_status  o_status,
    output logic                  o_empty,
    output sfcs_pkg::t_result     o_head,
    input  logic                  i_pop
);

    sfcs_pkg::t_result r_q [4];
    logic [1:0]        r_rp;
    logic [2:0]        r_cnt;
    logic [1:0]        wp;
    logic              rd;

    assign o_empty         = (r_cnt == 3'd0);
    assign o_head          = r_q[r_rp];
    assign rd              = i_pop && !o_empty;
    assign wp              = r_rp + r_cnt[1:0];
    // Room for the two results one command can produce.
    assign o_status.room   = (r_cnt <= 3'd2);
    assign o_status.count  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (rd) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_nres} - {2'b0, rd};
        end
        if (i_nres != 2'd0) begin
            r_q[wp] <= i_res0;
        end
        if (i_nres == 2'd2) begin
            r_q[wp + 2'd1] <= i_res1;
        end
    end

endmodule

// ===== hw/rtl/sfcs_back.sv =====
module sfcs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_max_attempts,
    input  logic               i_valid,
    input  sfcs_pkg::t_cmd     i_cmd,
    input  logic               i_room,
    output logic               o_take,
    output logic [1:0]         o_nres,
    output sfcs_pkg::t_result  o_res0,
    output sfcs_pkg::t_result  o_res1
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_RD_OP, PH_RD_A2, PH_RD_A1, PH_RD_A0, PH_RD_DUMMY, PH_RD_DATA,
        PH_FETCH, PH_WREN_PG, PH_PG_OP, PH_PG_A2, PH_PG_A1, PH_PG_A0, PH_PG_WAIT,
        PH_PG_DATA, PH_WREN_SE, PH_SE_OP, PH_SE_A2, PH_SE_A1, PH_SE_A0,
        PH_WREN_CE, PH_CE_OP, PH_POLL_OP, PH_POLL_RX, PH_ID_OP, PH_ID_B1,
        PH_ID_B2, PH_ID_B3, PH_BUSY_OP, PH_BUSY_RX
    } t_phase;

    t_phase r_phase, n_phase;
    logic [23:0] r_fa, n_fa;
    logic [15:0] r_bl, n_bl;
    logic [15:0] r_rl, n_rl;
    logic [3:0]  r_pc, n_pc;
    logic [sfcs_pkg::CP_W-1:0] r_copy, n_copy;
    logic [sfcs_pkg::PD_W-1:0] r_pd, n_pd;
    logic [23:0] r_id, n_id;
    logic [sfcs_pkg::FI_W-1:0] r_fi, n_fi;
    logic        r_byp;
    logic [7:0]  r_byp_d;

    sfcs_pkg::t_item   it;
    sfcs_pkg::t_result res [2];
    logic [1:0]  nres;
    logic        eop;
    logic        eop_slot;
    logic        differ;
    logic        buffered;
    logic [sfcs_pkg::PD_W-1:0] pd_cur;
    logic [3:0]  pc_inc;
    logic [15:0] bl_dec;
    logic [sfcs_pkg::IDX_W-1:0] idx;
    logic [sfcs_pkg::IDX_W-1:0] n_idx;
    logic [sfcs_pkg::CP_W-1:0]  prev_copy;
    logic [sfcs_pkg::CP_W-1:0]  cp_next;
    logic [sfcs_pkg::CP_W-1:0]  rd_copy;
    logic [sfcs_pkg::IDX_W-1:0] rd_idx;
    logic        we;
    logic [sfcs_pkg::MEM_AW-1:0] waddr;
    logic [sfcs_pkg::MEM_AW-1:0] raddr;
    logic [7:0]  ram_q;
    logic [7:0]  rdata;

    function automatic logic [sfcs_pkg::MEM_AW-1:0] maddr(
        input logic [sfcs_pkg::CP_W-1:0] c, input logic [sfcs_pkg::IDX_W-1:0] i);
        return sfcs_pkg::MEM_AW'(c) * sfcs_pkg::MEM_AW'(sfcs_pkg::BUFFER_BYTES)
               + sfcs_pkg::MEM_AW'(i);
    endfunction

    function automatic logic [sfcs_pkg::CP_W-1:0] cprev(
        input logic [sfcs_pkg::CP_W-1:0] c);
        return (c == '0) ? sfcs_pkg::CP_W'(sfcs_pkg::COPIES - 1) : c - 1'b1;
    endfunction

    assign it        = i_cmd.item;
    assign o_take    = i_valid && i_room;
    assign buffered  = (r_rl <= 16'(sfcs_pkg::BUFFER_BYTES));
    assign idx       = sfcs_pkg::IDX_W'(r_rl - r_bl);
    assign prev_copy = cprev(r_copy);
    assign cp_next   = (r_copy == sfcs_pkg::CP_W'(sfcs_pkg::COPIES - 1)) ? '0
                                                                         : r_copy + 1'b1;
    assign pc_inc    = (r_pc < 4'd15) ? r_pc + 4'd1 : r_pc;
    assign bl_dec    = r_bl - 16'd1;
    assign rdata     = r_byp ? r_byp_d : ram_q;
    // The previous copy's byte was read from the registered RAM in the cycle before, using the indices now current.
    assign differ    = (r_phase == PH_RD_DATA) && buffered && (r_pc != 4'd0)
                       && (rdata != it.data_byte);
    assign pd_cur    = r_pd | sfcs_pkg::PD_W'(differ);

    always_comb begin
        n_phase  = r_phase;
        n_fa     = r_fa;
        n_bl     = r_bl;
        n_rl     = r_rl;
        n_pc     = r_pc;
        n_copy   = r_copy;
        n_pd     = r_pd;
        n_id     = r_id;
        n_fi     = r_fi;
        res[0]   = '0;
        res[1]   = '0;
        nres     = 2'd0;
        eop      = 1'b0;
        eop_slot = 1'b0;
        we       = 1'b0;
        waddr    = maddr(r_copy, idx);

        if (o_take) begin
            case (i_cmd.cls)
                sfcs_pkg::CL_START: begin
                    if (r_phase == PH_IDLE || r_phase == PH_FETCH) begin
                        n_fa = it.addr;
                        nres = 2'd1;
                        unique case (it.req_type)
                            sfcs_pkg::REQ_READ: begin
                                n_rl    = it.length;
                                n_bl    = it.length;
                                n_pc    = 4'd0;
                                n_copy  = '0;
                                n_pd    = '1;
                                res[0]  = sfcs_pkg::mk_bus(sfcs_pkg::OP_FAST_READ, 1'b0);
                                n_phase = PH_RD_OP;
                            end
                            sfcs_pkg::REQ_PG_START: begin
                                n_rl = (it.length > 16'(sfcs_pkg::PAGE_BYTES))
                                       ? 16'(sfcs_pkg::PAGE_BYTES) : it.length;
                                n_bl = n_rl;
                                res[0]  = sfcs_pkg::mk_bus(sfcs_pkg::OP_WREN, 1'b1);
                                n_phase = PH_WREN_PG;
                            end
                            sfcs_pkg::REQ_SE: begin
                                res[0]  = sfcs_pkg::mk_bus(sfcs_pkg::OP_WREN, 1'b1);
                                n_phase = PH_WREN_SE;
                            end
                            sfcs_pkg::REQ_CE: begin
                                res[0]  = sfcs_pkg::mk_bus(sfcs_pkg::OP_WREN, 1'b1);
                                n_phase = PH_WREN_CE;
                            end
                            sfcs_pkg::REQ_ID: begin
                                n_id    = '0;
                                res[0]  = sfcs_pkg::mk_bus(sfcs_pkg::OP_RDID, 1'b0);
                                n_phase = PH_ID_OP;
                            end
                            default: begin
                                res[0]  = sfcs_pkg::mk_bus(sfcs_pkg::OP_STATUS, 1'b0);
                                n_phase = PH_BUSY_OP;
                            end
                        endcase
                    end
                end
                sfcs_pkg::CL_PG_DATA: begin
                    if (r_phase == PH_PG_WAIT) begin
                        nres    = 2'd1;
                        res[0]  = sfcs_pkg::mk_bus(it.data_byte, r_bl == 16'd1);
                        n_phase = PH_PG_DATA;
                    end
                end
                sfcs_pkg::CL_FETCH: begin
                    if (r_phase == PH_FETCH) begin
                        nres   = 2'd1;
                        res[0] = sfcs_pkg::mk_host(rdata);
                        n_fi   = r_fi + 1'b1;
                        if (16'(n_fi) >= r_rl) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                sfcs_pkg::CL_BUS: begin
                    if (r_phase != PH_IDLE && r_phase != PH_FETCH
                            && r_phase != PH_PG_WAIT) begin
                        nres = 2'd1;
                        if (it.bus_error) begin
                            res[0]  = sfcs_pkg::mk_done(sfcs_pkg::ST_BUS_ERR, 1'b0, '0);
                            n_phase = PH_IDLE;
                        end else begin
                            unique case (r_phase)
                                PH_RD_OP: begin
                                    res[0] = sfcs_pkg::mk_bus(r_fa[23:16], 1'b0);
                                    n_phase = PH_RD_A2;
                                end
                                PH_RD_A2: begin
                                    res[0] = sfcs_pkg::mk_bus(r_fa[15:8], 1'b0);
                                    n_phase = PH_RD_A1;
                                end
                                PH_RD_A1: begin
                                    res[0] = sfcs_pkg::mk_bus(r_fa[7:0], 1'b0);
                                    n_phase = PH_RD_A0;
                                end
                                PH_RD_A0: begin
                                    res[0] = sfcs_pkg::mk_bus(8'h00, r_rl == 16'd0);
                                    n_phase = PH_RD_DUMMY;
                                end
                                PH_RD_DUMMY: begin
                                    if (r_rl == 16'd0) begin
                                        eop = 1'b1;
                                    end else begin
                                        n_bl   = r_rl;
                                        res[0] = sfcs_pkg::mk_bus(8'h00, r_rl == 16'd1);
                                        n_phase = PH_RD_DATA;
                                    end
                                end
                                PH_RD_DATA: begin
                                    if (!buffered) begin
                                        res[0] = sfcs_pkg::mk_host(it.data_byte);
                                    end else begin
                                        we   = 1'b1;
                                        n_pd = pd_cur;
                                    end
                                    n_bl = bl_dec;
                                    nres = buffered ? 2'd1 : 2'd2;
                                    if (bl_dec == 16'd0) begin
                                        if (!buffered) begin
                                            res[1] = sfcs_pkg::mk_done(sfcs_pkg::ST_OK,
                                                                       1'b0, '0);
                                            n_phase = PH_IDLE;
                                        end else begin
                                            eop = 1'b1;
                                        end
                                    end else begin
                                        res[buffered ? 0 : 1] =
                                            sfcs_pkg::mk_bus(8'h00, bl_dec == 16'd1);
                                    end
                                end
                                PH_WREN_PG: begin
                                    res[0] = sfcs_pkg::mk_bus(sfcs_pkg::OP_PROGRAM, 1'b0);
                                    n_phase = PH_PG_OP;
                                end
                                PH_PG_OP: begin
                                    res[0] = sfcs_pkg::mk_bus(r_fa[23:16], 1'b0);
                                    n_phase = PH_PG_A2;
                                end
                                PH_PG_A2: begin
                                    res[0] = sfcs_pkg::mk_bus(r_fa[15:8], 1'b0);
                                    n_phase = PH_PG_A1;
                                end
                                PH_PG_A1: begin
                                    res[0] = sfcs_pkg::mk_bus(r_fa[7:0], r_bl == 16'd0);
                                    n_phase = PH_PG_A0;
                                end
                                PH_PG_A0: begin
                                    if (r_bl == 16'd0) begin
                                        res[0] = sfcs_pkg::mk_bus(sfcs_pkg::OP_STATUS, 1'b0);
                                        n_phase = PH_POLL_OP;
                                    end else begin
                                        nres    = 2'd0;
                                        n_phase = PH_PG_WAIT;
                                    end
                                end
                                PH_PG_DATA: begin
                                    n_bl = bl_dec;
                                    if (bl_dec == 16'd0) begin
                                        res[0] = sfcs_pkg::mk_bus(sfcs_pkg::OP_STATUS, 1'b0);
                                        n_phase = PH_POLL_OP;
                                    end else begin
                                        nres    = 2'd0;
                                        n_phase = PH_PG_WAIT;
                                    end
                                end
                                PH_WREN_SE: begin
                                    res[0] = sfcs_pkg::mk_bus(sfcs_pkg::OP_SE, 1'b0);
                                    n_phase = PH_SE_OP;
                                end
                                PH_SE_OP: begin
                                    res[0] = sfcs_pkg::mk_bus(r_fa[23:16], 1'b0);
                                    n_phase = PH_SE_A2;
                                end
                                PH_SE_A2: begin
                                    res[0] = sfcs_pkg::mk_bus(r_fa[15:8], 1'b0);
                                    n_phase = PH_SE_A1;
                                end
                                PH_SE_A1: begin
                                    res[0] = sfcs_pkg::mk_bus(r_fa[7:0], 1'b1);
                                    n_phase = PH_SE_A0;
                                end
                                PH_SE_A0: begin
                                    res[0] = sfcs_pkg::mk_bus(sfcs_pkg::OP_STATUS, 1'b0);
                                    n_phase = PH_POLL_OP;
                                end
                                PH_WREN_CE: begin
                                    res[0] = sfcs_pkg::mk_bus(sfcs_pkg::OP_CE, 1'b1);
                                    n_phase = PH_CE_OP;
                                end
                                PH_POLL_OP: begin
                                    res[0] = sfcs_pkg::mk_bus(8'h00, 1'b1);
                                    n_phase = PH_POLL_RX;
                                end
                                PH_POLL_RX: begin
                                    if ((it.data_byte & sfcs_pkg::WIP_MASK) != 8'h00) begin
                                        res[0] = sfcs_pkg::mk_bus(sfcs_pkg::OP_STATUS, 1'b0);
                                        n_phase = PH_POLL_OP;
                                    end else begin
                                        res[0] = sfcs_pkg::mk_done(sfcs_pkg::ST_OK, 1'b0, '0);
                                        n_phase = PH_IDLE;
                                    end
                                end
                                PH_ID_OP: begin
                                    res[0] = sfcs_pkg::mk_bus(8'h00, 1'b0);
                                    n_phase = PH_ID_B1;
                                end
                                PH_ID_B1: begin
                                    n_id   = {r_id[15:0], it.data_byte};
                                    res[0] = sfcs_pkg::mk_bus(8'h00, 1'b0);
                                    n_phase = PH_ID_B2;
                                end
                                PH_ID_B2: begin
                                    n_id   = {r_id[15:0], it.data_byte};
                                    res[0] = sfcs_pkg::mk_bus(8'h00, 1'b1);
                                    n_phase = PH_ID_B3;
                                end
                                PH_ID_B3: begin
                                    n_id   = {r_id[15:0], it.data_byte};
                                    res[0] = sfcs_pkg::mk_done(sfcs_pkg::ST_OK, 1'b0,
                                                               {r_id[15:0], it.data_byte});
                                    n_phase = PH_IDLE;
                                end
                                PH_BUSY_OP: begin
                                    res[0] = sfcs_pkg::mk_bus(8'h00, 1'b1);
                                    n_phase = PH_BUSY_RX;
                                end
                                PH_BUSY_RX: begin
                                    res[0] = sfcs_pkg::mk_done(sfcs_pkg::ST_OK,
                                                               it.data_byte[0], '0);
                                    n_phase = PH_IDLE;
                                end
                                default: begin
                                    // Chip erase frame is complete.
                                    res[0] = sfcs_pkg::mk_done(sfcs_pkg::ST_OK, 1'b0, '0);
                                    n_phase = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase

            // End of a buffered read pass: agree, give up, or run another pass.
            if (eop) begin
                n_pc = pc_inc;
                if (pd_cur == '0) begin
                    n_fi   = '0;
                    res[eop_slot] = sfcs_pkg::mk_done(sfcs_pkg::ST_OK, 1'b0, '0);
                    n_phase = (r_rl != 16'd0) ? PH_FETCH : PH_IDLE;
                end else if (pc_inc >= i_max_attempts) begin
                    res[eop_slot] = sfcs_pkg::mk_done(sfcs_pkg::ST_MISMATCH, 1'b0, '0);
                    n_phase = PH_IDLE;
                end else begin
                    n_copy = cp_next;
                    n_pd   = pd_cur << 1;
                    res[eop_slot] = sfcs_pkg::mk_bus(sfcs_pkg::OP_FAST_READ, 1'b0);
                    n_phase = PH_RD_OP;
                end
            end

            if (nres == 2'd2) begin
                res[1].last = 1'b1;
            end else if (nres == 2'd1) begin
                res[0].last = 1'b1;
            end
        end
    end

    // Read address follows the next state so the data is ready for the next beat.
    assign n_idx   = sfcs_pkg::IDX_W'(n_rl - n_bl);
    assign rd_copy = (n_phase == PH_FETCH) ? n_copy : cprev(n_copy);
    assign rd_idx  = (n_phase == PH_FETCH) ? n_fi[sfcs_pkg::IDX_W-1:0] : n_idx;
    assign raddr   = maddr(rd_copy, rd_idx);

    assign o_nres = nres;
    assign o_res0 = res[0];
    assign o_res1 = res[1];

    sfcs_ram #(
        .WIDTH(8),
        .DEPTH(sfcs_pkg::MEM_DEPTH)
    ) u_copies (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(it.data_byte),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fa    <= '0;
            r_bl    <= '0;
            r_rl    <= '0;
            r_pc    <= '0;
            r_copy  <= '0;
            r_pd    <= '0;
            r_id    <= '0;
            r_fi    <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_fa    <= n_fa;
            r_bl    <= n_bl;
            r_rl    <= n_rl;
            r_pc    <= n_pc;
            r_copy  <= n_copy;
            r_pd    <= n_pd;
            r_id    <= n_id;
            r_fi    <= n_fi;
            r_byp   <= we && (waddr == raddr);
        end
        r_byp_d <= it.data_byte;
    end

endmodule

// ===== hw/rtl/spi_nor_flash_command_sequencer_unit.sv =====
// Input beats are held in a command queue and results in a result queue.
// Throughput: one input beat per cycle while full is low; the sequencer takes
// one command a cycle if the result queue has room for a command's two results.
// Copy compares use the registered read of the single copy RAM.
// Reset is synchronous: queues empty, sequencer idle, attempt limit back to 9.
module spi_nor_flash_command_sequencer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  sfcs_pkg::t_item    i_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output sfcs_pkg::t_result  o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic                 r_max_attempts;
    logic [3:0]           r_max;
    logic                 cmd_valid;
    sfcs_pkg::t_cmd       cmd;
    logic                 cmd_take;
    sfcs_pkg::t_oq_status oq;
    logic [1:0]           nres;
    sfcs_pkg::t_result    res0;
    logic                 cfg_wr;
    sfcs_pkg::t_result    res1;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == sfcs_pkg::REG_MAX_ATTEMPTS);
    assign prdata = (paddr[2] == sfcs_pkg::REG_MAX_ATTEMPTS) ? {28'd0, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max          <= sfcs_pkg::ATTEMPTS_RESET;
            r_max_attempts <= 1'b0;
        end else begin
            r_max_attempts <= cfg_wr;
            if (cfg_wr) begin
                r_max <= pwdata[3:0];
            end
        end
    end

    sfcs_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (i_item),
        .o_full (full),
        .o_valid(cmd_valid),
        .o_cmd  (cmd),
        .i_take (cmd_take)
    );

    sfcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_attempts(r_max),
        .i_valid       (cmd_valid),
        .i_cmd         (cmd),
        .i_room        (oq.room),
        .o_take        (cmd_take),
        .o_nres        (nres),
        .o_res0        (res0),
        .o_res1        (res1)
    );

    sfcs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_nres  (nres),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_status(oq),
        .o_empty (empty),
        .o_head  (o_result),
        .i_pop   (pop)
    );

    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> (oq.count <= 3'd2))
        else $error("command taken without result queue room");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq.count <= 3'd4)
        else $error("result queue overflow");

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result lost");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_attempts |-> (r_max == $past(pwdata[3:0])))
        else $error("attempt limit not written");

endmodule

// ===== test/spi_nor_flash_command_sequencer_checker.sv =====
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_checker
    import sfcs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  logic     full,
    input  t_item    i_item,
    input  logic     empty,
    input  logic     pop,
    input  t_result  o_result,
    input  logic     psel,
    input  logic     penable,
    input  logic     pwrite,
    input  logic     pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int       o_errors,
    output int       o_pending
);

    typedef enum int {
        S_IDLE, S_RD_OP, S_RD_A2, S_RD_A1, S_RD_A0, S_RD_DUMMY, S_RD_DATA,
        S_FETCH, S_WREN_PG, S_PG_OP, S_PG_A2, S_PG_A1, S_PG_A0, S_PG_WAIT,
        S_PG_DATA, S_WREN_SE, S_SE_OP, S_SE_A2, S_SE_A1, S_SE_A0,
        S_WREN_CE, S_CE_OP, S_POLL_OP, S_POLL_RX, S_ID_OP, S_ID_B1,
        S_ID_B2, S_ID_B3, S_BUSY_OP, S_BUSY_RX
    } t_seq_state;

    localparam logic [PD_W-1:0] DIFF_ALL = '1;

    t_result    expected_results[$];
    t_seq_state seq;
    logic [3:0]  attempt_limit;
    logic [23:0] cur_addr;
    logic [15:0] remaining;
    logic [15:0] req_len;
    logic [3:0]  passes;
    int          copy_sel;
    logic [PD_W-1:0] diffs;
    logic [7:0]  copies [MEM_DEPTH];
    logic [23:0] id_acc;
    int          fetch_pos;
    int          errors;

    assign o_errors  = errors;
    assign o_pending = expected_results.size();

    task automatic report(input string what, input t_result got, input t_result want);
        errors++;
        $display("%0t mismatch %s: got %p expected %p", $realtime, what, got, want);
    endtask

    function automatic void add_bus(input logic [7:0] b, input logic fe,
                                    input t_seq_state nxt);
        t_result r;
        r = '0;
        r.out_kind = KIND_BUS;
        r.bus_out_byte = b;
        r.frame_end = fe;
        seq = nxt;
        expected_results.push_back(r);
    endfunction

    function automatic void add_done(input logic [1:0] st, input logic busy,
                                     input logic [23:0] id);
        t_result r;
        r = '0;
        r.out_kind = KIND_DONE;
        r.status = st;
        r.busy_flag = busy;
        r.device_id = id;
        seq = S_IDLE;
        expected_results.push_back(r);
    endfunction

    function automatic void add_host(input logic [7:0] b);
        t_result r;
        r = '0;
        r.out_kind = KIND_HOST;
        r.host_byte = b;
        expected_results.push_back(r);
    endfunction

    function automatic void finish_pass();
        if (passes < 4'd15)
            passes++;
        if (diffs == '0) begin
            fetch_pos = 0;
            add_done(ST_OK, 1'b0, '0);
            if (req_len != 0)
                seq = S_FETCH;
        end else if (passes >= attempt_limit) begin
            add_done(ST_MISMATCH, 1'b0, '0);
        end else begin
            copy_sel = (copy_sel + 1) % COPIES;
            diffs = (diffs << 1) & DIFF_ALL;
            add_bus(OP_FAST_READ, 1'b0, S_RD_OP);
        end
    endfunction

    function automatic void answer_byte(input logic [7:0] b);
        int idx;
        int prev;
        case (seq)
            S_RD_OP: add_bus(cur_addr[23:16], 1'b0, S_RD_A2);
            S_RD_A2: add_bus(cur_addr[15:8], 1'b0, S_RD_A1);
            S_RD_A1: add_bus(cur_addr[7:0], 1'b0, S_RD_A0);
            S_RD_A0: add_bus(8'h00, req_len == 0, S_RD_DUMMY);
            S_RD_DUMMY: begin
                if (req_len == 0) begin
                    finish_pass();
                end else begin
                    remaining = req_len;
                    add_bus(8'h00, remaining == 1, S_RD_DATA);
                end
            end
            S_RD_DATA: begin
                if (req_len > BUFFER_BYTES) begin
                    add_host(b);
                end else begin
                    idx = (int'(req_len) - int'(remaining)) % BUFFER_BYTES;
                    if (passes > 0) begin
                        prev = (copy_sel + COPIES - 1) % COPIES;
                        if (copies[prev * BUFFER_BYTES + idx] != b)
                            diffs[0] = 1'b1;
                    end
                    copies[copy_sel * BUFFER_BYTES + idx] = b;
                end
                remaining = remaining - 16'd1;
                if (remaining == 0) begin
                    if (req_len > BUFFER_BYTES)
                        add_done(ST_OK, 1'b0, '0);
                    else
                        finish_pass();
                end else begin
                    add_bus(8'h00, remaining == 1, S_RD_DATA);
                end
            end
            S_WREN_PG: add_bus(OP_PROGRAM, 1'b0, S_PG_OP);
            S_PG_OP: add_bus(cur_addr[23:16], 1'b0, S_PG_A2);
            S_PG_A2: add_bus(cur_addr[15:8], 1'b0, S_PG_A1);
            S_PG_A1: add_bus(cur_addr[7:0], remaining == 0, S_PG_A0);
            S_PG_A0: begin
                if (remaining == 0)
                    add_bus(OP_STATUS, 1'b0, S_POLL_OP);
                else
                    seq = S_PG_WAIT;
            end
            S_PG_DATA: begin
                remaining = remaining - 16'd1;
                if (remaining == 0)
                    add_bus(OP_STATUS, 1'b0, S_POLL_OP);
                else
                    seq = S_PG_WAIT;
            end
            S_WREN_SE: add_bus(OP_SE, 1'b0, S_SE_OP);
            S_SE_OP: add_bus(cur_addr[23:16], 1'b0, S_SE_A2);
            S_SE_A2: add_bus(cur_addr[15:8], 1'b0, S_SE_A1);
            S_SE_A1: add_bus(cur_addr[7:0], 1'b1, S_SE_A0);
            S_SE_A0: add_bus(OP_STATUS, 1'b0, S_POLL_OP);
            S_WREN_CE: add_bus(OP_CE, 1'b1, S_CE_OP);
            S_CE_OP: add_done(ST_OK, 1'b0, '0);
            S_POLL_OP: add_bus(8'h00, 1'b1, S_POLL_RX);
            S_POLL_RX: begin
                if ((b & WIP_MASK) != 0)
                    add_bus(OP_STATUS, 1'b0, S_POLL_OP);
                else
                    add_done(ST_OK, 1'b0, '0);
            end
            S_ID_OP: add_bus(8'h00, 1'b0, S_ID_B1);
            S_ID_B1: begin
                id_acc = {id_acc[15:0], b};
                add_bus(8'h00, 1'b0, S_ID_B2);
            end
            S_ID_B2: begin
                id_acc = {id_acc[15:0], b};
                add_bus(8'h00, 1'b1, S_ID_B3);
            end
            S_ID_B3: begin
                id_acc = {id_acc[15:0], b};
                add_done(ST_OK, 1'b0, id_acc);
            end
            S_BUSY_OP: add_bus(8'h00, 1'b1, S_BUSY_RX);
            S_BUSY_RX: add_done(ST_OK, b[0], '0);
            default: ;
        endcase
    endfunction

    function automatic void predict(input t_item it);
        int prior_size;
        prior_size = expected_results.size();
        case (it.req_type)
            REQ_READ, REQ_PG_START, REQ_SE, REQ_CE, REQ_ID, REQ_BUSY: begin
                if (seq == S_IDLE || seq == S_FETCH) begin
                    cur_addr = it.addr;
                    case (it.req_type)
                        REQ_READ: begin
                            req_len = it.length;
                            remaining = it.length;
                            passes = '0;
                            copy_sel = 0;
                            diffs = DIFF_ALL;
                            add_bus(OP_FAST_READ, 1'b0, S_RD_OP);
                        end
                        REQ_PG_START: begin
                            req_len = (it.length > PAGE_BYTES) ? 16'(PAGE_BYTES) : it.length;
                            remaining = req_len;
                            add_bus(OP_WREN, 1'b1, S_WREN_PG);
                        end
                        REQ_SE: add_bus(OP_WREN, 1'b1, S_WREN_SE);
                        REQ_CE: add_bus(OP_WREN, 1'b1, S_WREN_CE);
                        REQ_ID: begin
                            id_acc = '0;
                            add_bus(OP_RDID, 1'b0, S_ID_OP);
                        end
                        default: add_bus(OP_STATUS, 1'b0, S_BUSY_OP);
                    endcase
                end
            end
            REQ_PG_DATA: begin
                if (seq == S_PG_WAIT)
                    add_bus(it.data_byte, remaining == 1, S_PG_DATA);
            end
            REQ_BUS_BYTE: begin
                if (seq != S_IDLE && seq != S_FETCH && seq != S_PG_WAIT) begin
                    if (it.bus_error)
                        add_done(ST_BUS_ERR, 1'b0, '0);
                    else
                        answer_byte(it.data_byte);
                end
            end
            REQ_FETCH: begin
                if (seq == S_FETCH) begin
                    add_host(copies[copy_sel * BUFFER_BYTES + fetch_pos % BUFFER_BYTES]);
                    fetch_pos++;
                    if (fetch_pos >= req_len)
                        seq = S_IDLE;
                end
            end
            default: ;
        endcase
        if (expected_results.size() > prior_size)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            seq = S_IDLE;
            attempt_limit = ATTEMPTS_RESET;
            passes = '0;
            copy_sel = 0;
            diffs = '0;
            id_acc = '0;
            fetch_pos = 0;
            req_len = '0;
            remaining = '0;
            cur_addr = '0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report("unexpected beat", o_result, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.out_kind != want.out_kind)
                        report("out_kind", o_result, want);
                    else if (o_result.bus_out_byte != want.bus_out_byte)
                        report("bus_out_byte", o_result, want);
                    else if (o_result.frame_end != want.frame_end)
                        report("frame_end", o_result, want);
                    else if (o_result.host_byte != want.host_byte)
                        report("host_byte", o_result, want);
                    else if (o_result.status != want.status)
                        report("status", o_result, want);
                    else if (o_result.busy_flag != want.busy_flag)
                        report("busy_flag", o_result, want);
                    else if (o_result.device_id != want.device_id)
                        report("device_id", o_result, want);
                    else if (o_result.last != want.last)
                        report("last", o_result, want);
                end
            end
            if (push && !full)
                predict(i_item);
            if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_ATTEMPTS)
                attempt_limit = pwdata[3:0];
        end
    end

    initial errors = 0;

endmodule

// ===== test/spi_nor_flash_command_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_unit_tb;
    import sfcs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    t_item       i_item;
    logic        full;
    logic        empty;
    logic        pop;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          idle_cycles;
    bit          long_hold;
    bit          timed_out;

    spi_nor_flash_command_sequencer_unit DUT (.*);

    spi_nor_flash_command_sequencer_checker scoreboard (
        .i_clk, .i_rst_n, .push, .full, .i_item, .empty, .pop, .o_result,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: counts cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out) begin
            timed_out = 1'b1;
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold requested by the stimulus.
    initial begin
        int gap;
        pop = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                pop <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Push stays high between back-to-back beats; it is dropped by a gap or a drain.
    task automatic send(input t_item it);
        int gap;
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) :
              ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk iff !full);
    endtask

    function automatic t_item make(input logic [3:0] kind, input logic [23:0] a,
                                   input logic [15:0] len, input logic [7:0] d,
                                   input logic err);
        t_item it;
        it.req_type = kind;
        it.addr = a;
        it.length = len;
        it.data_byte = d;
        it.bus_error = err;
        return it;
    endfunction

    task automatic wait_quiet();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [3:0] v);
        wait_quiet();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {28'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic bus_reply(input logic [7:0] d, input logic err);
        send(make(REQ_BUS_BYTE, $urandom, $urandom, d, err));
    endtask

    // A buffered read; flaky passes make the copies disagree at random.
    task automatic do_read(input logic [15:0] len, input bit flaky, input int replies);
        logic [7:0] pattern [16];
        for (int i = 0; i < 16; i++)
            pattern[i] = $urandom;
        send(make(REQ_READ, $urandom, len, $urandom, 1'b0));
        for (int i = 0; i < replies; i++) begin
            if (flaky && $urandom_range(0, 5) == 0)
                bus_reply($urandom, 1'b0);
            else
                bus_reply(pattern[i % 16], 1'b0);
        end
    endtask

    task automatic random_item();
        int pick;
        logic [15:0] len;
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1, 2: begin
                len = $urandom_range(0, 6);
                do_read(len, $urandom_range(0, 1), (len + 5) * 4);
                for (int i = 0; i < $urandom_range(0, len + 1); i++)
                    send(make(REQ_FETCH, $urandom, $urandom, $urandom, $urandom));
            end
            3: begin
                // Streamed read, cut short by a bus error after a few bytes.
                send(make(REQ_READ, $urandom, 16'(1025 + $urandom_range(0, 3)), 0, 0));
                for (int i = 0; i < 12; i++)
                    bus_reply($urandom, 1'b0);
                bus_reply($urandom, 1'b1);
            end
            4, 5, 6: begin
                len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : $urandom_range(0, 4);
                send(make(REQ_PG_START, $urandom, len, $urandom, 1'b0));
                for (int i = 0; i < 5; i++)
                    bus_reply($urandom, 1'b0);
                for (int i = 0; i < 5; i++) begin
                    send(make(REQ_PG_DATA, $urandom, $urandom, $urandom, 1'b0));
                    bus_reply($urandom, 1'b0);
                end
                for (int i = 0; i < 4; i++)
                    bus_reply($urandom_range(0, 1) ? 8'hFE : 8'hFF, 1'b0);
            end
            7, 8: begin
                send(make($urandom_range(0, 1) ? REQ_SE : REQ_CE, $urandom, $urandom, 0, 0));
                for (int i = 0; i < 9; i++)
                    bus_reply($urandom, $urandom_range(0, 30) == 0);
            end
            9, 10: begin
                send(make($urandom_range(0, 1) ? REQ_ID : REQ_BUSY, $urandom, $urandom, 0, 0));
                for (int i = 0; i < 4; i++)
                    bus_reply($urandom, $urandom_range(0, 20) == 0);
            end
            default: send(make(4'($urandom), $urandom, $urandom, $urandom, $urandom));
        endcase
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_cycles = 0;
        long_hold = 1'b0;
        timed_out = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all request kinds but sector erase and page data, extreme fields, errors and odd items.
        send(make(REQ_ID, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1));
        bus_reply(8'hFF, 1'b0);
        bus_reply(8'h00, 1'b0);
        bus_reply(8'hA5, 1'b0);
        bus_reply(8'hFF, 1'b0);
        send(make(REQ_BUSY, 24'h0, 16'h0, 8'h0, 1'b0));
        bus_reply(8'h00, 1'b0);
        bus_reply(8'hFF, 1'b0);
        send(make(REQ_CE, 24'h0, 16'h1, 8'h0, 1'b0));
        bus_reply(8'h00, 1'b1);
        send(make(REQ_FETCH, 24'h0, 16'h0, 8'h0, 1'b0));
        send(make(4'hF, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1));
        send(make(REQ_PG_START, 24'h123456, 16'h0, 8'h0, 1'b0));
        for (int i = 0; i < 8; i++)
            bus_reply(8'h01 & i[7:0], 1'b0);
        do_read(16'd0, 1'b0, 16);
        send(make(REQ_FETCH, 24'h0, 16'h0, 8'h0, 1'b0));

        // Attempt limit at its extremes, including below the agreement depth.
        write_limit(4'd15);
        do_read(16'd3, 1'b1, 60);
        write_limit(4'd0);
        do_read(16'd2, 1'b1, 14);
        write_limit(4'd3);

        // Long hold on the result side while items keep coming.
        long_hold = 1'b1;
        send(make(REQ_SE, 24'hABCDEF, 16'h0, 8'h0, 1'b0));
        for (int i = 0; i < 40; i++)
            bus_reply(8'h01, 1'b0);
        bus_reply(8'h00, 1'b0);
        wait_quiet();

        for (int k = 0; k < 45; k++) begin
            random_item();
            if (k == 15)
                write_limit(4'd5);
            if (k == 30)
                write_limit(4'd9);
        end

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sfcs_pkg.sv
hw/rtl/sfcs_ram.sv
hw/rtl/sfcs_front.sv
hw/rtl/sfcs_outq.sv
hw/rtl/sfcs_back.sv
hw/rtl/spi_nor_flash_command_sequencer_unit.sv
test/spi_nor_flash_command_sequencer_checker.sv
test/spi_nor_flash_command_sequencer_unit_tb.sv
